// ----- rtl/core/mffc_pkg.sv -----
// Package for the mean face flux convergence core.
// Holds the sequencer state codes, divider operation codes and fixed widths.
// No dependencies; the core top level, mffc_out_if and the testbench use it by scoped names.
package mffc_pkg;

	localparam int COND_W    = 16;  // Q8.8 conductivity
	localparam int ACC_W     = 64;  // Q56.8 flux accumulator
	localparam int MEAN_W    = 40;  // Q32.8 mean flux
	localparam int CHG_W     = 32;  // Q16.16 relative change
	localparam int DIV_W     = 40;  // widest divisor: count or mean magnitude
	localparam int STEP_W    = 6;   // divider step counter
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_SOLID = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FLUID = 1'b1;

	localparam logic [COND_W-1:0] COND_RESET = 16'd256;

	// Steps of the restoring divider: the conductivity numerator has 33 bits.
	localparam logic [STEP_W-1:0] COND_LAST_STEP = 6'd32;
	localparam logic [STEP_W-1:0] FULL_LAST_STEP = 6'd63;
	localparam int                COND_ALIGN     = 31;

	localparam logic [ACC_W-1:0]  MEAN_POS_LIMIT = 64'd549755813887;
	localparam logic [ACC_W-1:0]  MEAN_NEG_LIMIT = 64'd549755813888;
	localparam logic [MEAN_W-1:0] MEAN_POS_SAT   = 40'h7F_FFFF_FFFF;
	localparam logic [MEAN_W-1:0] MEAN_NEG_SAT   = 40'h80_0000_0000;
	localparam logic [ACC_W-1:0]  ACC_POS_SAT    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [ACC_W-1:0]  ACC_NEG_SAT    = 64'h8000_0000_0000_0000;

	typedef logic [DIV_W-1:0] div_t;
	typedef logic [ACC_W-1:0] dvd_t;

	typedef enum logic [10:0] {
		S_IDLE     = 11'b000_0000_0001,
		S_CMUL     = 11'b000_0000_0010,
		S_CDIV_LD  = 11'b000_0000_0100,
		S_DIV      = 11'b000_0000_1000,
		S_FMUL     = 11'b000_0001_0000,
		S_ACC      = 11'b000_0010_0000,
		S_MEAN_LD  = 11'b000_0100_0000,
		S_MEAN_FIX = 11'b000_1000_0000,
		S_CHG_LD   = 11'b001_0000_0000,
		S_CHG_FIX  = 11'b010_0000_0000,
		S_OUT      = 11'b100_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		OP_COND = 2'd0,
		OP_MEAN = 2'd1,
		OP_CHG  = 2'd2
	} div_op_t;

endpackage

// ----- rtl/core/mffc_in_if.sv -----
// Input channel of the mean face flux convergence core: one voxel pair a beat.
// Carries valid, ready and the pair fields; no package dependency.
interface mffc_in_if #(
	parameter int TEMP_BITS = 24
);
	logic                        valid;
	logic                        ready;
	logic                        upper_is_solid;
	logic                        lower_is_solid;
	logic signed [TEMP_BITS-1:0] upper_temperature;
	logic signed [TEMP_BITS-1:0] lower_temperature;
	logic                        last_pair;
	logic                        track_change;

	modport source (
		output valid, upper_is_solid, lower_is_solid, upper_temperature,
		       lower_temperature, last_pair, track_change,
		input  ready
	);

	modport sink (
		input  valid, upper_is_solid, lower_is_solid, upper_temperature,
		       lower_temperature, last_pair, track_change,
		output ready
	);
endinterface

// ----- rtl/core/mffc_out_if.sv -----
// Result channel of the mean face flux convergence core: one pass result a beat.
// Field widths come from mffc_pkg.
interface mffc_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [mffc_pkg::MEAN_W-1:0] mean_flux;
	logic        [mffc_pkg::CHG_W-1:0]  relative_change;
	logic                               empty_set;
	logic                               sum_saturated;

	modport source (
		output valid, mean_flux, relative_change, empty_set, sum_saturated,
		input  ready
	);

	modport sink (
		input  valid, mean_flux, relative_change, empty_set, sum_saturated,
		output ready
	);
endinterface

// ----- rtl/core/mean_face_flux_convergence_core.sv -----
// Mean face flux convergence core: top level, sequencer and shared units.
// Depends on mffc_pkg, mffc_in_if and mffc_out_if.
//
// Use: each beat on pair_in is one vertical voxel pair. The core works out the
// face conductivity (the shared value for a like pair, the rounded harmonic
// mean for a mixed pair), multiplies it by the temperature drop and adds the
// product into a saturating 64-bit accumulator while counting the pairs. The
// beat marked last_pair closes the pass: one beat then appears on result_out
// with the rounded mean flux and, when track_change is set, the relative change
// against the stored previous mean, which is then replaced.
// A mixed pair takes longer than a like pair, since the harmonic mean runs
// 33 steps of the shared restoring divider. The last pair adds the 64-step
// mean division, and the change division when the change is tracked and the
// mean is not zero. pair_in.ready is high only between items.
// One multiplier serves both the conductivity product and the flux product.
// A finished result sits in the output register; while the receiver stalls,
// the core keeps taking pairs and holds only when a second result is ready.
// Reset clears the pass state, the previous mean and the output valid, and
// loads both conductivities with 1.0. cfg_we writes a conductivity at once.
module mean_face_flux_convergence_core #(
	parameter int COUNT_BITS = 24,
	parameter int TEMP_BITS  = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mffc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mffc_pkg::COND_W-1:0]       cfg_data,
	mffc_in_if.sink                           pair_in,
	mffc_out_if.source                        result_out
);

	localparam int DW = TEMP_BITS + 1;          // temperature difference
	localparam int MA = mffc_pkg::COND_W + 1;   // signed conductivity operand
	localparam int PW = DW + MA;                // product
	localparam int CW = COUNT_BITS + 1;         // pair count, holds 2^COUNT_BITS
	localparam int AW = mffc_pkg::ACC_W;
	localparam int MW = mffc_pkg::MEAN_W;
	localparam int KW = mffc_pkg::COND_W;
	localparam int VW = mffc_pkg::DIV_W;
	localparam logic [CW-1:0] CNT_MAX = CW'(1) << COUNT_BITS;

	// Configuration registers.
	logic [KW-1:0] solid_q, fluid_q;

	// Latched pair.
	logic                 up_solid_q, lo_solid_q, last_q, track_q;
	logic [TEMP_BITS-1:0] up_temp_q, lo_temp_q;

	// Sequencer and working registers.
	mffc_pkg::state_t  state_q;
	mffc_pkg::div_op_t op_q;
	logic [KW-1:0]     k_q;
	logic signed [PW-1:0] prod_q;
	logic [AW-1:0]     acc_q;
	logic [CW-1:0]     cnt_q;
	logic              sat_q;
	logic [MW-1:0]     mean_q, prev_q;
	logic              empty_q;
	logic [mffc_pkg::CHG_W-1:0] chg_q;

	// Shared divider.
	mffc_pkg::div_t         den_q, rem_q, rem_nxt;
	mffc_pkg::dvd_t         quo_q, quo_nxt;
	logic [mffc_pkg::STEP_W-1:0] step_q;
	logic [VW:0]            trial;
	logic                   div_ge;

	// Output register.
	logic                 out_vld_q;
	logic [MW-1:0]        out_mean_q;
	logic [mffc_pkg::CHG_W-1:0] out_chg_q;
	logic                 out_empty_q, out_sat_q;

	// Combinational helpers.
	logic [KW-1:0]        cond_a, cond_b;
	logic [KW:0]          cond_sum;
	logic signed [DW-1:0] temp_diff;
	logic signed [MA-1:0] mul_a;
	logic signed [DW-1:0] mul_b;
	logic signed [PW-1:0] mul_p;
	logic [32:0]          cond_dvd;
	logic [AW:0]          acc_sum;
	logic [AW-1:0]        acc_mag;
	logic [AW-1:0]        mean_q1;
	logic                 mean_round;
	logic signed [MW:0]   mean_delta;
	logic [MW:0]          delta_mag;
	logic [MW-1:0]        mean_mag;
	logic                 in_go, out_go;

	assign cond_a   = up_solid_q ? solid_q : fluid_q;
	assign cond_b   = lo_solid_q ? solid_q : fluid_q;
	assign cond_sum = {1'b0, cond_a} + {1'b0, cond_b};

	assign temp_diff = $signed({up_temp_q[TEMP_BITS-1], up_temp_q})
	                 - $signed({lo_temp_q[TEMP_BITS-1], lo_temp_q});

	// The one multiplier: a*b while finding the harmonic mean, k*dT otherwise.
	always_comb begin
		if (state_q == mffc_pkg::S_CMUL) begin
			mul_a = $signed({1'b0, cond_a});
			mul_b = $signed(DW'(cond_b));
		end else begin
			mul_a = $signed({1'b0, k_q});
			mul_b = temp_diff;
		end
	end
	assign mul_p = mul_a * mul_b;

	// 2ab + (a+b)/2; a*b stays below 2^32.
	assign cond_dvd = {prod_q[31:0], 1'b0} + 33'(cond_sum[KW:1]);

	// One restoring divider step.
	assign trial   = {rem_q, quo_q[AW-1]};
	assign div_ge  = trial >= {1'b0, den_q};
	assign rem_nxt = div_ge ? VW'(trial - {1'b0, den_q}) : trial[VW-1:0];
	assign quo_nxt = {quo_q[AW-2:0], div_ge};

	assign acc_sum = {acc_q[AW-1], acc_q} + {{(AW + 1 - PW){prod_q[PW-1]}}, prod_q};
	assign acc_mag = acc_q[AW-1] ? AW'(0 - acc_q) : acc_q;

	// Round to nearest, ties away from zero: 2r >= count.
	assign mean_round = {rem_q, 1'b0} >= {1'b0, den_q};
	assign mean_q1    = quo_q + AW'(mean_round);

	assign mean_delta = $signed({mean_q[MW-1], mean_q}) - $signed({prev_q[MW-1], prev_q});
	assign delta_mag  = mean_delta[MW] ? (MW + 1)'(0 - mean_delta) : mean_delta;
	assign mean_mag   = mean_q[MW-1] ? MW'(0 - mean_q) : mean_q;

	assign pair_in.ready = state_q == mffc_pkg::S_IDLE;
	assign in_go  = pair_in.valid && pair_in.ready;
	assign out_go = (state_q == mffc_pkg::S_OUT) && (!out_vld_q || result_out.ready);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= mffc_pkg::COND_RESET;
			fluid_q <= mffc_pkg::COND_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mffc_pkg::REG_SOLID: solid_q <= cfg_data;
				mffc_pkg::REG_FLUID: fluid_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pair latch; payload needs no reset.
	always_ff @(posedge clk) begin
		if (in_go) begin
			up_solid_q <= pair_in.upper_is_solid;
			lo_solid_q <= pair_in.lower_is_solid;
			up_temp_q  <= pair_in.upper_temperature;
			lo_temp_q  <= pair_in.lower_temperature;
			last_q     <= pair_in.last_pair;
			track_q    <= pair_in.track_change;
		end
	end

	// Sequencer with the pass state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mffc_pkg::S_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			sat_q   <= 1'b0;
			prev_q  <= '0;
		end else begin
			case (state_q)
				mffc_pkg::S_IDLE: begin
					if (in_go) begin
						if (pair_in.upper_is_solid != pair_in.lower_is_solid) begin
							state_q <= mffc_pkg::S_CMUL;
						end else begin
							state_q <= mffc_pkg::S_FMUL;
						end
					end
				end
				mffc_pkg::S_CMUL: begin
					state_q <= mffc_pkg::S_CDIV_LD;
				end
				mffc_pkg::S_CDIV_LD: begin
					if (cond_sum == '0) begin
						state_q <= mffc_pkg::S_FMUL;
					end else begin
						state_q <= mffc_pkg::S_DIV;
					end
				end
				mffc_pkg::S_DIV: begin
					if (step_q == '0) begin
						case (op_q)
							mffc_pkg::OP_COND: state_q <= mffc_pkg::S_FMUL;
							mffc_pkg::OP_MEAN: state_q <= mffc_pkg::S_MEAN_FIX;
							mffc_pkg::OP_CHG:  state_q <= mffc_pkg::S_CHG_FIX;
							default:           state_q <= mffc_pkg::S_IDLE;
						endcase
					end
				end
				mffc_pkg::S_FMUL: begin
					state_q <= mffc_pkg::S_ACC;
				end
				mffc_pkg::S_ACC: begin
					if (acc_sum[AW] != acc_sum[AW-1]) begin
						acc_q <= acc_sum[AW] ? mffc_pkg::ACC_NEG_SAT : mffc_pkg::ACC_POS_SAT;
						sat_q <= 1'b1;
					end else begin
						acc_q <= acc_sum[AW-1:0];
					end
					if (cnt_q != CNT_MAX) begin
						cnt_q <= cnt_q + CW'(1);
					end
					state_q <= last_q ? mffc_pkg::S_MEAN_LD : mffc_pkg::S_IDLE;
				end
				mffc_pkg::S_MEAN_LD: begin
					state_q <= (cnt_q == '0) ? mffc_pkg::S_CHG_LD : mffc_pkg::S_DIV;
				end
				mffc_pkg::S_MEAN_FIX: begin
					state_q <= mffc_pkg::S_CHG_LD;
				end
				mffc_pkg::S_CHG_LD: begin
					if (track_q && mean_q != '0) begin
						state_q <= mffc_pkg::S_DIV;
					end else begin
						state_q <= mffc_pkg::S_OUT;
					end
				end
				mffc_pkg::S_CHG_FIX: begin
					state_q <= mffc_pkg::S_OUT;
				end
				mffc_pkg::S_OUT: begin
					if (out_go) begin
						if (track_q) begin
							prev_q <= mean_q;
						end
						acc_q   <= '0;
						cnt_q   <= '0;
						sat_q   <= 1'b0;
						state_q <= mffc_pkg::S_IDLE;
					end
				end
				default: state_q <= mffc_pkg::S_IDLE;
			endcase
		end
	end

	// Working registers of the multiplier, the divider and the result.
	always_ff @(posedge clk) begin
		case (state_q)
			mffc_pkg::S_IDLE: begin
				k_q <= pair_in.upper_is_solid ? solid_q : fluid_q;
			end
			mffc_pkg::S_CMUL: begin
				prod_q <= mul_p;
			end
			mffc_pkg::S_CDIV_LD: begin
				// A mixed pair whose conductivities are both zero conducts nothing.
				k_q    <= '0;
				op_q   <= mffc_pkg::OP_COND;
				den_q  <= mffc_pkg::div_t'(cond_sum);
				rem_q  <= '0;
				quo_q  <= {cond_dvd, {mffc_pkg::COND_ALIGN{1'b0}}};
				step_q <= mffc_pkg::COND_LAST_STEP;
			end
			mffc_pkg::S_DIV: begin
				rem_q  <= rem_nxt;
				quo_q  <= quo_nxt;
				step_q <= step_q - mffc_pkg::STEP_W'(1);
				if (op_q == mffc_pkg::OP_COND) begin
					k_q <= quo_nxt[KW-1:0];
				end
			end
			mffc_pkg::S_FMUL: begin
				prod_q <= mul_p;
			end
			mffc_pkg::S_MEAN_LD: begin
				empty_q <= cnt_q == '0;
				mean_q  <= '0;
				op_q    <= mffc_pkg::OP_MEAN;
				den_q   <= mffc_pkg::div_t'(cnt_q);
				rem_q   <= '0;
				quo_q   <= acc_mag;
				step_q  <= mffc_pkg::FULL_LAST_STEP;
			end
			mffc_pkg::S_MEAN_FIX: begin
				if (acc_q[AW-1]) begin
					mean_q <= (mean_q1 > mffc_pkg::MEAN_NEG_LIMIT) ? mffc_pkg::MEAN_NEG_SAT
					                                               : MW'(0 - mean_q1);
				end else begin
					mean_q <= (mean_q1 > mffc_pkg::MEAN_POS_LIMIT) ? mffc_pkg::MEAN_POS_SAT
					                                               : mean_q1[MW-1:0];
				end
			end
			mffc_pkg::S_CHG_LD: begin
				chg_q  <= '0;
				op_q   <= mffc_pkg::OP_CHG;
				den_q  <= mean_mag;
				rem_q  <= '0;
				quo_q  <= AW'({delta_mag, 16'd0}) + AW'(mean_mag[MW-1:1]);
				step_q <= mffc_pkg::FULL_LAST_STEP;
			end
			mffc_pkg::S_CHG_FIX: begin
				chg_q <= (|quo_q[AW-1:mffc_pkg::CHG_W]) ? '1 : quo_q[mffc_pkg::CHG_W-1:0];
			end
			default: ;
		endcase
	end

	// Output register: a result waits here while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_go) begin
			out_vld_q <= 1'b1;
		end else if (result_out.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_go) begin
			out_mean_q  <= mean_q;
			out_chg_q   <= chg_q;
			out_empty_q <= empty_q;
			out_sat_q   <= sat_q;
		end
	end

	assign result_out.valid           = out_vld_q;
	assign result_out.mean_flux       = $signed(out_mean_q);
	assign result_out.relative_change = out_chg_q;
	assign result_out.empty_set       = out_empty_q;
	assign result_out.sum_saturated   = out_sat_q;

	// The partial remainder of the divider always stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mffc_pkg::S_DIV) |-> (rem_q < den_q))
		else $error("divider remainder not below divisor");

	// The pair count never passes its hold value.
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_MAX)
		else $error("pair count beyond its limit");

	// Handing over a result clears the pass state.
	a_pass_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_go |=> (cnt_q == '0 && acc_q == '0 && !sat_q))
		else $error("pass state not cleared after result");

	// A result appears only from the hand-over state.
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == mffc_pkg::S_OUT))
		else $error("result valid without hand-over");

endmodule

// ----- tb/mffc_flux_checker.sv -----
`timescale 1ns / 1ps
// Checker for the mean face flux convergence core: follows both channels and the
// conductivity writes, predicts every pass result and compares it beat by beat.
// Depends on mffc_pkg, mffc_in_if and mffc_out_if.
module mffc_flux_checker #(
	parameter int COUNT_BITS = 24,
	parameter int TEMP_BITS  = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mffc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mffc_pkg::COND_W-1:0]    cfg_data,
	mffc_in_if                             pair_in,
	mffc_out_if                            result_out,
	output int                             failures,
	output int                             outstanding
);

	typedef struct packed {
		logic [mffc_pkg::MEAN_W-1:0] mean;
		logic [mffc_pkg::CHG_W-1:0]  change;
		logic                        empty_set;
		logic                        saturated;
	} pass_result_t;

	logic [mffc_pkg::COND_W-1:0]       solid_k      = mffc_pkg::COND_RESET;
	logic [mffc_pkg::COND_W-1:0]       fluid_k      = mffc_pkg::COND_RESET;
	logic signed [mffc_pkg::ACC_W-1:0] running_flux = '0;
	logic [63:0]                       pair_total   = '0;
	logic signed [63:0]                prior_mean   = '0;
	logic                              sat_flag     = 1'b0;
	pass_result_t                      awaited[$];
	int                                mismatch_count  = 0;
	int                                pending_results = 0;

	assign failures    = mismatch_count;
	assign outstanding = pending_results;

	function automatic logic [63:0] face_k(input logic us, input logic ls);
		logic [63:0] a, b, s;
		a = us ? 64'(solid_k) : 64'(fluid_k);
		b = ls ? 64'(solid_k) : 64'(fluid_k);
		if (us == ls)
			return a;
		s = a + b;
		if (s == 64'd0)
			return 64'd0;
		return (64'd2 * a * b + (s >> 1)) / s;
	endfunction

	function automatic logic [63:0] magnitude64(input logic signed [63:0] v);
		return v[63] ? 64'd0 - v : v;
	endfunction

	// Folds one pair into the running pass; returns 1 with the result on the
	// pair that closes the pass.
	function automatic bit absorb_pair(input logic us, input logic ls,
			input logic signed [TEMP_BITS-1:0] ut, input logic signed [TEMP_BITS-1:0] lt,
			input logic last, input logic track, output pass_result_t res);
		logic signed [63:0]          upper_wide, lower_wide, diff, prod, mean64;
		logic signed [64:0]          wide;
		logic [63:0]                 mag, q, r, den, num;
		logic [mffc_pkg::CHG_W-1:0]  change;
		logic                        empty;
		upper_wide = ut;
		lower_wide = lt;
		diff = upper_wide - lower_wide;
		prod = $signed(face_k(us, ls)) * diff;
		wide = running_flux;
		wide = wide + prod;
		if (wide[64] != wide[63]) begin
			running_flux = wide[64] ? mffc_pkg::ACC_NEG_SAT : mffc_pkg::ACC_POS_SAT;
			sat_flag = 1'b1;
		end else begin
			running_flux = wide[63:0];
		end
		if (pair_total < (64'd1 << COUNT_BITS))
			pair_total = pair_total + 64'd1;
		res = '0;
		if (!last)
			return 1'b0;

		empty  = (pair_total == 64'd0);
		mean64 = '0;
		if (!empty) begin
			mag = magnitude64(running_flux);
			q   = mag / pair_total;
			r   = mag % pair_total;
			if (r >= pair_total - r)
				q = q + 64'd1;
			if (running_flux[63])
				mean64 = 64'd0 - ((q > mffc_pkg::MEAN_NEG_LIMIT) ? mffc_pkg::MEAN_NEG_LIMIT : q);
			else
				mean64 = (q > mffc_pkg::MEAN_POS_LIMIT) ? mffc_pkg::MEAN_POS_LIMIT : q;
		end

		change = '0;
		if (track) begin
			if (mean64 != 64'sd0) begin
				den    = magnitude64(mean64);
				num    = magnitude64(mean64 - prior_mean) << 16;
				q      = (num + (den >> 1)) / den;
				change = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[mffc_pkg::CHG_W-1:0];
			end
			prior_mean = mean64;
		end

		res.mean      = mean64[mffc_pkg::MEAN_W-1:0];
		res.change    = change;
		res.empty_set = empty;
		res.saturated = sat_flag;
		running_flux = '0;
		pair_total   = '0;
		sat_flag     = 1'b0;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pass_result_t fresh, oldest;
		if (!arst_n) begin
			solid_k      = mffc_pkg::COND_RESET;
			fluid_k      = mffc_pkg::COND_RESET;
			running_flux = '0;
			pair_total   = '0;
			prior_mean   = '0;
			sat_flag     = 1'b0;
			awaited.delete();
			pending_results = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mffc_pkg::REG_SOLID: solid_k = cfg_data;
					mffc_pkg::REG_FLUID: fluid_k = cfg_data;
					default: ;
				endcase
			end
			if (pair_in.valid && pair_in.ready) begin
				if (absorb_pair(pair_in.upper_is_solid, pair_in.lower_is_solid,
						pair_in.upper_temperature, pair_in.lower_temperature,
						pair_in.last_pair, pair_in.track_change, fresh))
					awaited.push_back(fresh);
			end
			if (result_out.valid && result_out.ready) begin
				if (awaited.size() == 0) begin
					if (mismatch_count < 10)
						$display("%0t: result beat with nothing awaited: mean %0d change %0d",
							$realtime, result_out.mean_flux, result_out.relative_change);
					mismatch_count++;
				end else begin
					oldest = awaited.pop_front();
					if (result_out.mean_flux !== oldest.mean ||
							result_out.relative_change !== oldest.change ||
							result_out.empty_set !== oldest.empty_set ||
							result_out.sum_saturated !== oldest.saturated) begin
						if (mismatch_count < 10)
							$display({"%0t: result mismatch: mean %0d/%0d change %0d/%0d ",
								"empty %b/%b saturated %b/%b (expected/actual)"},
								$realtime, $signed(oldest.mean), result_out.mean_flux,
								oldest.change, result_out.relative_change,
								oldest.empty_set, result_out.empty_set,
								oldest.saturated, result_out.sum_saturated);
						mismatch_count++;
					end
				end
			end
			pending_results = awaited.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Top of the testbench for the mean face flux convergence core: clock, reset,
// conductivity writes, voxel pair stimulus, result back-pressure and the verdict.
// Depends on mffc_pkg, mffc_in_if, mffc_out_if, the core and mffc_flux_checker.
module testbench;

	localparam int COUNT_BITS    = 24;
	localparam int TEMP_BITS     = 24;
	// Idle wait after a drain: long enough for a tracked last pair to finish inside
	// the core, so that it is quiet before a conductivity write.
	localparam int SETTLE_CYCLES = 200;
	// Long enough for the output register to fill and a second result to wait.
	localparam int HOLD_CYCLES   = 600;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int PHASE_PAIRS   = 130;

	localparam logic signed [TEMP_BITS-1:0] T_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
	localparam logic signed [TEMP_BITS-1:0] T_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

	logic                           clk    = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we;
	logic [mffc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mffc_pkg::COND_W-1:0]    cfg_data;
	int                             failures;
	int                             outstanding;
	int                             cycle_count  = 0;
	// calm switches off all idling on both sides for the closing phase.
	bit                             calm         = 1'b0;
	// Set by the stimulus, taken and cleared by the receiver.
	bit                             hold_off_req = 1'b0;

	mffc_in_if #(.TEMP_BITS(TEMP_BITS)) pair_in ();
	mffc_out_if                         result_out ();

	mean_face_flux_convergence_core #(
		.COUNT_BITS(COUNT_BITS),
		.TEMP_BITS (TEMP_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pair_in   (pair_in),
		.result_out(result_out)
	);

	mffc_flux_checker #(
		.COUNT_BITS(COUNT_BITS),
		.TEMP_BITS (TEMP_BITS)
	) flux_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pair_in    (pair_in),
		.result_out (result_out),
		.failures   (failures),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Offers one voxel pair and returns at the edge where the beat is taken.
	// valid is left high on purpose: the caller either offers the next beat or
	// lowers valid in the same time step, so no beat is ever taken twice.
	task automatic send_pair(input logic us, input logic ls,
			input logic signed [TEMP_BITS-1:0] ut, input logic signed [TEMP_BITS-1:0] lt,
			input logic last, input logic track);
		if (!calm && $urandom_range(0, 4) == 0) begin
			pair_in.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		pair_in.valid             <= 1'b1;
		pair_in.upper_is_solid    <= us;
		pair_in.lower_is_solid    <= ls;
		pair_in.upper_temperature <= ut;
		pair_in.lower_temperature <= lt;
		pair_in.last_pair         <= last;
		pair_in.track_change      <= track;
		@(posedge clk);
		while (!pair_in.ready)
			@(posedge clk);
	endtask

	// Stops offering pairs, waits for every awaited result and then lets the
	// core finish whatever it may still be doing.
	task automatic drain_and_settle();
		pair_in.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Both conductivities are written on back-to-back edges while the core is idle.
	task automatic load_conductivities(input logic [mffc_pkg::COND_W-1:0] solid,
			input logic [mffc_pkg::COND_W-1:0] fluid);
		cfg_we    <= 1'b1;
		cfg_index <= mffc_pkg::REG_SOLID;
		cfg_data  <= solid;
		@(posedge clk);
		cfg_index <= mffc_pkg::REG_FLUID;
		cfg_data  <= fluid;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
	endtask

	// Temperatures: extremes, values around zero (so that drops are small and
	// means come out near zero), and fully random words for the remaining bits.
	function automatic logic signed [TEMP_BITS-1:0] pick_temp();
		case ($urandom_range(0, 7))
			0:       return T_MAX;
			1:       return T_MIN;
			2, 3:    return TEMP_BITS'($urandom_range(0, 512)) - TEMP_BITS'(256);
			default: return TEMP_BITS'($urandom());
		endcase
	endfunction

	// Streams whole passes of random pairs until the budget is spent. Every
	// pass ends on a last pair, so the core is never left mid-pass.
	task automatic stream_passes(input int pair_budget, input int max_len);
		int sent, len;
		logic closing;
		sent = 0;
		while (sent < pair_budget) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40)
				: $urandom_range(1, max_len);
			for (int i = 0; i < len; i++) begin
				closing = (i == len - 1);
				send_pair(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					pick_temp(), pick_temp(), closing,
					closing ? ($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 1)));
			end
			sent += len;
		end
	endtask

	// Receiver: ready runs in random stretches of acceptance and of stall. Once
	// asked, it holds off for a long stretch counted here, so the core fills its
	// output register, finishes a second result and stops taking pairs.
	initial begin : receiver
		result_out.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				result_out.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				result_out.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				result_out.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		logic [mffc_pkg::COND_W-1:0] solid, fluid;

		pair_in.valid             <= 1'b0;
		pair_in.upper_is_solid    <= 1'b0;
		pair_in.lower_is_solid    <= 1'b0;
		pair_in.upper_temperature <= '0;
		pair_in.lower_temperature <= '0;
		pair_in.last_pair         <= 1'b0;
		pair_in.track_change      <= 1'b0;
		cfg_we                    <= 1'b0;
		cfg_index                 <= mffc_pkg::REG_SOLID;
		cfg_data                  <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Conductivities straight out of reset (1.0 each). A full-scale drop in
		// both directions, a pass whose mean is zero so the change must read zero,
		// an untracked pass that must leave the stored mean alone, and a mixed pass.
		send_pair(1'b0, 1'b0, T_MAX, T_MIN, 1'b1, 1'b1);
		send_pair(1'b1, 1'b1, T_MIN, T_MAX, 1'b1, 1'b1);
		send_pair(1'b0, 1'b1, 24'sd300, 24'sd300, 1'b1, 1'b1);
		send_pair(1'b1, 1'b0, 24'sd4096, -24'sd4096, 1'b1, 1'b0);
		send_pair(1'b0, 1'b1, 24'sd1000, -24'sd2000, 1'b0, 1'b0);
		send_pair(1'b1, 1'b1, -24'sd5, 24'sd7, 1'b0, 1'b1);
		send_pair(1'b1, 1'b0, T_MAX, 24'sd0, 1'b1, 1'b1);
		drain_and_settle();

		// Smallest conductivities: sums of one over two pairs land exactly on a
		// half, so the mean rounding is seen to go away from zero both ways.
		load_conductivities(16'd1, 16'd1);
		send_pair(1'b0, 1'b0, 24'sd1, 24'sd0, 1'b0, 1'b0);
		send_pair(1'b0, 1'b0, 24'sd0, 24'sd0, 1'b1, 1'b1);
		send_pair(1'b1, 1'b0, -24'sd1, 24'sd0, 1'b0, 1'b0);
		send_pair(1'b0, 1'b1, 24'sd0, 24'sd0, 1'b1, 1'b1);
		drain_and_settle();

		// Largest against smallest: a solid pair with the full drop overflows the
		// 40-bit mean in both signs, and the mixed pairs exercise the harmonic mean.
		load_conductivities(16'd65535, 16'd1);
		send_pair(1'b1, 1'b1, T_MAX, T_MIN, 1'b1, 1'b1);
		send_pair(1'b1, 1'b1, T_MIN, T_MAX, 1'b1, 1'b1);
		send_pair(1'b1, 1'b0, T_MAX, T_MIN, 1'b1, 1'b1);
		send_pair(1'b0, 1'b1, T_MIN, T_MAX, 1'b1, 1'b0);
		drain_and_settle();

		// Both conductivities zero: a mixed pair has a zero conductivity sum and
		// its face conductivity must come out as zero.
		load_conductivities(16'd0, 16'd0);
		send_pair(1'b1, 1'b0, T_MAX, T_MIN, 1'b0, 1'b0);
		send_pair(1'b0, 1'b1, 24'sd100, -24'sd100, 1'b0, 1'b0);
		send_pair(1'b0, 1'b0, 24'sd5, 24'sd1, 1'b1, 1'b1);
		drain_and_settle();

		load_conductivities(16'd65535, 16'd65535);
		send_pair(1'b0, 1'b1, T_MAX, T_MIN, 1'b1, 1'b1);
		send_pair(1'b1, 1'b1, 24'sd0, 24'sd0, 1'b1, 1'b1);
		drain_and_settle();

		// Random phases, each under its own conductivity setting. Phase four
		// carries the long receiver hold-off with a burst of one-pair passes, and
		// the closing phase runs with no idling on either side.
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: begin solid = 16'd65535; fluid = 16'd65535; end
				1: begin solid = 16'd1;     fluid = 16'd1;     end
				2: begin solid = 16'd1;     fluid = 16'd65535; end
				3: begin solid = 16'd65535; fluid = 16'd1;     end
				default: begin
					solid = mffc_pkg::COND_W'($urandom_range(1, 65535));
					fluid = mffc_pkg::COND_W'($urandom_range(1, 65535));
				end
			endcase
			if (phase == 7)
				calm = 1'b1;
			load_conductivities(solid, fluid);
			if (phase == 4) begin
				hold_off_req = 1'b1;
				stream_passes(40, 1);
			end
			stream_passes(PHASE_PAIRS, 8);
			drain_and_settle();
		end

		if (failures == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/mffc_pkg.sv
rtl/core/mffc_in_if.sv
rtl/core/mffc_out_if.sv
rtl/core/mean_face_flux_convergence_core.sv
tb/mffc_flux_checker.sv
tb/testbench.sv
